### sv/argtok_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the argument tokenizer.
// No dependencies; used by every module of the block.
package argtok_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_BYTE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ARG_END  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST_END = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_QUOTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNESCAPE_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_BACKSLASH = 2'd2;

    localparam int QUEUE_DEPTH_DEF = 4;

    // Up to three results of one item, always in this order:
    // held-back space, byte, token end.
    typedef struct packed {
        logic       sp;
        logic       byte_v;
        logic [7:0] data;
        logic       tend;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

### sv/argtok_front.sv
`timescale 1ns / 1ps
// Front part: accepts items, holds configuration and tokenizer flags,
// and builds one result bundle per item. Depends on argtok_pkg.
module argtok_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [argtok_pkg::CMD_W-1:0] i_cmd,
    input  logic [7:0]                  i_byte,
    input  logic                        i_cfg_valid,
    input  logic [argtok_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                        i_cfg_data,
    input  argtok_pkg::t_qstat          i_qstat,
    output logic                        o_push,
    output argtok_pkg::t_bundle         o_bundle
);

    logic r_strip_q, r_unesc, r_strip_bs;
    logic r_in_q, r_esc, r_sp, r_has;
    logic n_in_q, n_esc, n_sp, n_has;
    logic accept;

    always_comb begin
        logic       do_add;
        logic       do_end;
        logic       force_end;
        logic       clr;
        logic [7:0] add_c;
        argtok_pkg::t_bundle b;
        do_add    = 1'b0;
        do_end    = 1'b0;
        force_end = 1'b0;
        clr       = 1'b0;
        add_c     = i_byte;
        n_in_q    = r_in_q;
        n_esc     = r_esc;
        b         = '0;
        case (i_cmd)
            argtok_pkg::CMD_BYTE: begin
                if (r_esc) begin
                    n_esc  = 1'b0;
                    do_add = 1'b1;
                end else if (r_in_q) begin
                    if (i_byte == argtok_pkg::CH_QUOTE) begin
                        n_in_q    = 1'b0;
                        do_add    = !r_strip_q;
                        do_end    = 1'b1;
                        force_end = 1'b1;
                    end else begin
                        do_add = 1'b1;
                    end
                end else if (i_byte == argtok_pkg::CH_QUOTE) begin
                    n_in_q = 1'b1;
                    do_add = !r_strip_q;
                end else if (i_byte == argtok_pkg::CH_SPACE || i_byte == argtok_pkg::CH_TAB
                             || i_byte == argtok_pkg::CH_CR || i_byte == argtok_pkg::CH_LF) begin
                    do_end = 1'b1;
                end else if (r_unesc && i_byte == argtok_pkg::CH_BSLASH) begin
                    n_esc  = 1'b1;
                    do_add = !r_strip_bs;
                end else begin
                    do_add = 1'b1;
                end
            end
            argtok_pkg::CMD_ARG_END: begin
                if (r_in_q) begin
                    do_add = 1'b1;
                    add_c  = argtok_pkg::CH_SPACE;
                end else begin
                    do_end = 1'b1;
                end
            end
            argtok_pkg::CMD_LIST_END: begin
                do_end = 1'b1;
                clr    = 1'b1;
            end
            default: begin
            end
        endcase

        // emit held-back space, then hold back a new one or emit the byte
        b.sp   = do_add & r_sp;
        b.data = add_c;
        n_has  = r_has | b.sp;
        n_sp   = r_sp;
        if (do_add) begin
            if (add_c == argtok_pkg::CH_SPACE) begin
                n_sp = 1'b1;
            end else begin
                b.byte_v = 1'b1;
                n_has    = 1'b1;
                n_sp     = 1'b0;
            end
        end
        if (do_end) begin
            n_sp   = 1'b0;
            b.tend = force_end | n_has;
            n_has  = 1'b0;
        end
        if (clr) begin
            n_in_q = 1'b0;
            n_esc  = 1'b0;
        end
        o_bundle = b;
    end

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (o_bundle.sp || o_bundle.byte_v || o_bundle.tend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_q <= 1'b0;
            r_esc  <= 1'b0;
            r_sp   <= 1'b0;
            r_has  <= 1'b0;
        end else if (accept) begin
            r_in_q <= n_in_q;
            r_esc  <= n_esc;
            r_sp   <= n_sp;
            r_has  <= n_has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_q  <= 1'b0;
            r_unesc    <= 1'b1;
            r_strip_bs <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                argtok_pkg::CFG_STRIP_QUOTES:    r_strip_q  <= i_cfg_data;
                argtok_pkg::CFG_UNESCAPE_ENABLE: r_unesc    <= i_cfg_data;
                argtok_pkg::CFG_STRIP_BACKSLASH: r_strip_bs <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

### sv/argtok_queue.sv
`timescale 1ns / 1ps
// Short bundle queue between front and back parts.
// Depends on argtok_pkg.
module argtok_queue #(
    parameter int DEPTH = argtok_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  argtok_pkg::t_bundle i_push_data,
    input  logic                i_pop,
    output argtok_pkg::t_bundle o_head,
    output argtok_pkg::t_qstat  o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    argtok_pkg::t_bundle r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### sv/argtok_back.sv
`timescale 1ns / 1ps
// Back part: splits each queued bundle into single results and drives
// the registered output stream. Depends on argtok_pkg.
module argtok_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  argtok_pkg::t_bundle i_head,
    input  argtok_pkg::t_qstat  i_qstat,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_data,
    output logic                o_tend,
    output logic                o_last
);

    logic r_valid, r_tend, r_last;
    logic [7:0] r_data;
    logic r_sp_done, r_b_done;
    logic load, have, use_sp, use_b, is_last;
    logic [7:0] sel_data;

    assign load = !r_valid || i_ready;
    assign have = !i_qstat.empty;

    always_comb begin
        use_sp  = i_head.sp && !r_sp_done;
        use_b   = !use_sp && i_head.byte_v && !r_b_done;
        sel_data = '0;
        if (use_sp) begin
            sel_data = argtok_pkg::CH_SPACE;
            is_last  = !(i_head.byte_v || i_head.tend);
        end else if (use_b) begin
            sel_data = i_head.data;
            is_last  = !i_head.tend;
        end else begin
            is_last  = 1'b1;
        end
    end

    assign o_pop = load && have && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_sp_done <= 1'b0;
            r_b_done  <= 1'b0;
        end else if (load) begin
            r_valid <= have;
            if (have) begin
                if (is_last) begin
                    r_sp_done <= 1'b0;
                    r_b_done  <= 1'b0;
                end else begin
                    r_sp_done <= r_sp_done | use_sp;
                    r_b_done  <= r_b_done | use_b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && have) begin
            r_data <= sel_data;
            r_tend <= !(use_sp || use_b);
            r_last <= is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_tend  = r_tend;
    assign o_last  = r_last;

endmodule

### sv/argument_tokenizer_core.sv
`timescale 1ns / 1ps
// Top level of the argument tokenizer: front, bundle queue and back part.
// Depends on argtok_pkg, argtok_front, argtok_queue, argtok_back.
//
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tuser[1:0] command, tdata[7:0] in_byte
// m_axis    out  tvalid/tready           tdata[7:0] out_byte, tuser token_end,
//                                        tlast last_result
// cfg       in   valid/ready (ready=1)   index[1:0] register, data[0] value
//
// One item accepted per cycle while the bundle queue has room; each item
// yields zero to three results, sent one per cycle from the output register
// while m_axis tready is high; results pass the queue, then that register.
// Throughput is set by the single-result-per-cycle output port; the queue
// absorbs bursts of multi-result items. Output stalls back up through the
// queue to s_axis tready. Reset is synchronous, active low.
module argument_tokenizer_core #(
    parameter int QUEUE_DEPTH = argtok_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tuser,   // [0] token_end
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data
);

    argtok_pkg::t_bundle push_data, head;
    argtok_pkg::t_qstat  qstat;
    logic push, pop;

    assign o_cfg_ready = 1'b1;

    argtok_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_cmd       (i_s_axis_tuser),
        .i_byte      (i_s_axis_tdata),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_bundle    (push_data)
    );

    argtok_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (qstat)
    );

    argtok_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_tend  (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("token end not last result of its item");

    a_end_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == 8'h00)
        else $error("token end carries a byte");

    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue both full and empty");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule
